// ===== rtl/expression_lexer_macros.svh =====
// Assertion macros for the expression lexer checker.
// Depends on nothing; included by the checker file.
`ifndef EXPRESSION_LEXER_MACROS_SVH
`define EXPRESSION_LEXER_MACROS_SVH

// Checks that the consequent holds in the cycle after the antecedent, outside reset.
`define EXPLEX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same check, but also evaluated while reset is asserted.
`define EXPLEX_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/explex_pkg.sv =====
// Shared types, constants and helper functions for the expression lexer.
// Depends on nothing; used by every other lexer file but the macro header.
package explex_pkg;

   localparam int unsigned PosBits     = 16;
   localparam int unsigned CharBits    = 8;
   localparam int unsigned FieldBits   = 16;
   localparam int unsigned KindBits    = 4;
   localparam int unsigned FifoDepth   = 4;
   localparam int unsigned FifoAddrBits = $clog2(FifoDepth);
   localparam int unsigned FifoCountBits = $clog2(FifoDepth + 1);

   localparam logic [FieldBits-1:0] FieldMax = '1;

   localparam logic [CharBits-1:0] CharNul   = 8'h00;
   localparam logic [CharBits-1:0] CharSpace = 8'h20;
   localparam logic [CharBits-1:0] CharDot   = 8'h2E;
   localparam logic [CharBits-1:0] CharMinus = 8'h2D;
   localparam logic [CharBits-1:0] CharPlus  = 8'h2B;
   localparam logic [CharBits-1:0] CharStar  = 8'h2A;
   localparam logic [CharBits-1:0] CharSlash = 8'h2F;
   localparam logic [CharBits-1:0] CharCaret = 8'h5E;
   localparam logic [CharBits-1:0] CharPercent = 8'h25;
   localparam logic [CharBits-1:0] CharOpen  = 8'h28;
   localparam logic [CharBits-1:0] CharClose = 8'h29;

   typedef enum logic [KindBits-1:0] {
      KIND_NAME   = 4'd0,
      KIND_NUMBER = 4'd1,
      KIND_ADD    = 4'd2,
      KIND_NEGATE = 4'd3,
      KIND_MUL    = 4'd4,
      KIND_DIV    = 4'd5,
      KIND_POWER  = 4'd6,
      KIND_REM    = 4'd7,
      KIND_OPEN   = 4'd8,
      KIND_CLOSE  = 4'd9,
      KIND_ERROR  = 4'd10
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_NAME   = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_MINUS  = 2'd3
   } mode_type;

   typedef struct packed {
      kind_type             kind;
      logic [FieldBits-1:0] start;
      logic [FieldBits-1:0] length;
      logic [FieldBits-1:0] serial;
      logic                 last;
   } token_type;

   typedef struct packed {
      mode_type             mode;
      logic [PosBits-1:0]   run_start;
      logic [PosBits-1:0]   position;
      logic [FieldBits-1:0] emitted;
   } lex_state_type;

   function automatic kind_type pending_kind(input mode_type mode);
      kind_type k;
      unique case (mode)
         MODE_NAME:   k = KIND_NAME;
         MODE_NUMBER: k = KIND_NUMBER;
         MODE_MINUS:  k = KIND_NEGATE;
         default:     k = KIND_ERROR;
      endcase
      return k;
   endfunction

   // Length of a pending run that ends just before end_excl, at least one.
   function automatic logic [PosBits:0] run_length(input mode_type mode,
                                                  input logic [PosBits-1:0] start,
                                                  input logic [PosBits:0] end_excl);
      logic [PosBits:0] s;
      s = {1'b0, start};
      if (mode == MODE_MINUS || end_excl <= s) begin
         return (PosBits+1)'(1);
      end
      return end_excl - s;
   endfunction

   // Saturates a position or length to the width of a result field.
   function automatic logic [FieldBits-1:0] clamp_field(input logic [PosBits:0] v);
      logic [32:0] w;
      w = 33'(v);
      if (w > 33'(FieldMax)) begin
         return FieldMax;
      end
      return w[FieldBits-1:0];
   endfunction

endpackage

// ===== rtl/explex_req_if.sv =====
// Character channel into the expression lexer: valid, ready and one character.
// Depends on explex_pkg for the character width.
interface explex_req_if;
   logic                             valid;
   logic                             ready;
   logic [explex_pkg::CharBits-1:0]  char_code;
   logic                             end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== rtl/explex_rsp_if.sv =====
// Token channel out of the expression lexer: valid, ready and one token.
// Depends on explex_pkg for field widths.
interface explex_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [explex_pkg::KindBits-1:0]   token_kind;
   logic [explex_pkg::FieldBits-1:0]  token_start;
   logic [explex_pkg::FieldBits-1:0]  token_length;
   logic [explex_pkg::FieldBits-1:0]  token_serial;
   logic                              last_of_run;

   modport source (output valid, output token_kind, output token_start,
                   output token_length, output token_serial, output last_of_run,
                   input ready);
   modport sink (input valid, input token_kind, input token_start,
                 input token_length, input token_serial, input last_of_run,
                 output ready);
endinterface

// ===== rtl/explex_step.sv =====
// Next-state and token logic for one character of the expression lexer.
// Depends on explex_pkg; purely combinational, used by expression_lexer.
module explex_step (
   input  explex_pkg::lex_state_type         state,
   input  logic [explex_pkg::CharBits-1:0]   char_code,
   input  logic                              end_of_text,
   output explex_pkg::lex_state_type         state_in,
   output explex_pkg::token_type             token0,
   output explex_pkg::token_type             token1,
   output logic [1:0]                        emit_count
);

   logic                              is_letter;
   logic                              is_digit;
   logic                              is_dot;
   logic                              is_minus;
   logic                              is_blank;
   logic                              absorbed;
   explex_pkg::kind_type              op_kind;
   logic [explex_pkg::PosBits:0]      pos_ext;
   logic [explex_pkg::PosBits:0]      pos_next_ext;
   explex_pkg::mode_type              mode_after;
   logic [explex_pkg::PosBits-1:0]    start_after;
   logic                              flush_valid;
   logic                              fresh_valid;
   logic                              final_valid;
   explex_pkg::token_type             flush_tok;
   explex_pkg::token_type             fresh_tok;
   explex_pkg::token_type             final_tok;

   always_comb begin
      is_letter = (char_code >= 8'h41 && char_code <= 8'h5A) ||
                  (char_code >= 8'h61 && char_code <= 8'h7A);
      is_digit  = char_code >= 8'h30 && char_code <= 8'h39;
      is_dot    = char_code == explex_pkg::CharDot;
      is_minus  = char_code == explex_pkg::CharMinus;
      is_blank  = char_code == explex_pkg::CharSpace || char_code == explex_pkg::CharNul;

      unique case (char_code)
         explex_pkg::CharPlus:    op_kind = explex_pkg::KIND_ADD;
         explex_pkg::CharStar:    op_kind = explex_pkg::KIND_MUL;
         explex_pkg::CharSlash:   op_kind = explex_pkg::KIND_DIV;
         explex_pkg::CharCaret:   op_kind = explex_pkg::KIND_POWER;
         explex_pkg::CharPercent: op_kind = explex_pkg::KIND_REM;
         explex_pkg::CharOpen:    op_kind = explex_pkg::KIND_OPEN;
         explex_pkg::CharClose:   op_kind = explex_pkg::KIND_CLOSE;
         default:                 op_kind = explex_pkg::KIND_ERROR;
      endcase

      pos_ext      = {1'b0, state.position};
      pos_next_ext = pos_ext + (explex_pkg::PosBits+1)'(1);

      absorbed = (state.mode == explex_pkg::MODE_NAME && is_letter) ||
                 (state.mode == explex_pkg::MODE_NUMBER && (is_digit || is_dot)) ||
                 (state.mode == explex_pkg::MODE_MINUS && is_digit);

      // A pending run that the character does not continue is closed first.
      flush_valid      = !absorbed && state.mode != explex_pkg::MODE_IDLE;
      flush_tok.kind   = explex_pkg::pending_kind(state.mode);
      flush_tok.start  = explex_pkg::clamp_field({1'b0, state.run_start});
      flush_tok.length = explex_pkg::clamp_field(
         explex_pkg::run_length(state.mode, state.run_start, pos_ext));
      flush_tok.serial = '0;
      flush_tok.last   = 1'b0;

      fresh_valid      = 1'b0;
      fresh_tok.kind   = op_kind;
      fresh_tok.start  = explex_pkg::clamp_field(pos_ext);
      fresh_tok.length = explex_pkg::FieldBits'(1);
      fresh_tok.serial = '0;
      fresh_tok.last   = 1'b0;

      start_after = state.run_start;
      if (absorbed) begin
         mode_after = (state.mode == explex_pkg::MODE_MINUS) ?
                      explex_pkg::MODE_NUMBER : state.mode;
      end else if (is_letter) begin
         mode_after  = explex_pkg::MODE_NAME;
         start_after = state.position;
      end else if (is_digit) begin
         mode_after  = explex_pkg::MODE_NUMBER;
         start_after = state.position;
      end else if (is_minus) begin
         mode_after  = explex_pkg::MODE_MINUS;
         start_after = state.position;
      end else begin
         mode_after  = explex_pkg::MODE_IDLE;
         fresh_valid = !is_blank;
      end

      // The final character closes whatever run is still open, itself included.
      final_valid      = end_of_text && mode_after != explex_pkg::MODE_IDLE;
      final_tok.kind   = explex_pkg::pending_kind(mode_after);
      final_tok.start  = explex_pkg::clamp_field({1'b0, start_after});
      final_tok.length = explex_pkg::clamp_field(
         explex_pkg::run_length(mode_after, start_after, pos_next_ext));
      final_tok.serial = '0;
      final_tok.last   = 1'b0;

      token1 = final_tok;
      if (flush_valid) begin
         token0 = flush_tok;
         if (fresh_valid) begin
            token1 = fresh_tok;
         end
         emit_count = (fresh_valid || final_valid) ? 2'd2 : 2'd1;
      end else if (fresh_valid) begin
         token0     = fresh_tok;
         emit_count = 2'd1;
      end else begin
         token0     = final_tok;
         emit_count = final_valid ? 2'd1 : 2'd0;
      end
      token0.serial = state.emitted;
      token1.serial = state.emitted + explex_pkg::FieldBits'(1);
      token0.last   = emit_count == 2'd1;
      token1.last   = 1'b1;

      if (end_of_text) begin
         state_in.mode      = explex_pkg::MODE_IDLE;
         state_in.run_start = '0;
         state_in.position  = '0;
         state_in.emitted   = '0;
      end else begin
         state_in.mode      = mode_after;
         state_in.run_start = start_after;
         state_in.position  = (&state.position) ? state.position :
                              pos_next_ext[explex_pkg::PosBits-1:0];
         state_in.emitted   = state.emitted + explex_pkg::FieldBits'(emit_count);
      end
   end

endmodule

// ===== rtl/explex_queue.sv =====
// Small token queue that takes up to two tokens a cycle and sends one while the receiver is ready.
// Depends on explex_pkg and explex_rsp_if; used by expression_lexer.
module explex_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_count,
   input  explex_pkg::token_type  push0,
   input  explex_pkg::token_type  push1,
   output logic                   room_for_two,
   explex_rsp_if.source           rsp_chan
);

   explex_pkg::token_type                   entries_ff [explex_pkg::FifoDepth];
   logic [explex_pkg::FifoAddrBits-1:0]     wr_ptr_ff;
   logic [explex_pkg::FifoAddrBits-1:0]     wr_ptr_in;
   logic [explex_pkg::FifoAddrBits-1:0]     wr_next;
   logic [explex_pkg::FifoAddrBits-1:0]     rd_ptr_ff;
   logic [explex_pkg::FifoAddrBits-1:0]     rd_ptr_in;
   logic [explex_pkg::FifoCountBits-1:0]    count_ff;
   logic [explex_pkg::FifoCountBits-1:0]    count_in;
   logic                                    pop;
   explex_pkg::token_type                   head;

   always_comb begin
      pop          = rsp_chan.valid && rsp_chan.ready;
      room_for_two = count_ff <= explex_pkg::FifoCountBits'(explex_pkg::FifoDepth - 2);
      wr_next      = wr_ptr_ff + explex_pkg::FifoAddrBits'(1);
      wr_ptr_in    = wr_ptr_ff + explex_pkg::FifoAddrBits'(push_count);
      rd_ptr_in    = rd_ptr_ff + explex_pkg::FifoAddrBits'(pop);
      count_in     = count_ff + explex_pkg::FifoCountBits'(push_count) -
                     explex_pkg::FifoCountBits'(pop);
      head         = entries_ff[rd_ptr_ff];
   end

   assign rsp_chan.valid        = count_ff != '0;
   assign rsp_chan.token_kind   = head.kind;
   assign rsp_chan.token_start  = head.start;
   assign rsp_chan.token_length = head.length;
   assign rsp_chan.token_serial = head.serial;
   assign rsp_chan.last_of_run  = head.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entries_ff[wr_next] <= push1;
      end
   end

endmodule

// ===== rtl/expression_lexer.sv =====
// Top level of the streaming expression lexer: state registers, step logic, token queue.
// Depends on explex_pkg, explex_req_if, explex_rsp_if, explex_step and explex_queue.
//
//   Channel    Direction   Carries
//   req_chan   in          char_code, end_of_text
//   rsp_chan   out         token_kind, token_start, token_length, token_serial, last_of_run
//
// One character is taken per cycle while the queue has room for two; its tokens are written
// into a four-entry queue at the accepting edge and are offered from the next cycle.
// A character can yield two tokens, so the input pauses only while the queue holds three
// or more tokens.
// Synchronous reset clears the lexer state and empties the queue; no clearing pass is needed.
// A stalled output keeps its token while further characters fill the queue.
module expression_lexer (
   input  logic         clock,
   input  logic         reset,
   explex_req_if.sink   req_chan,
   explex_rsp_if.source rsp_chan
);

   explex_pkg::lex_state_type  state_ff;
   explex_pkg::lex_state_type  state_in;
   explex_pkg::token_type      token0;
   explex_pkg::token_type      token1;
   logic [1:0]                 emit_count;
   logic [1:0]                 push_count;
   logic                       room_for_two;
   logic                       accept;

   assign req_chan.ready = room_for_two;
   assign accept         = req_chan.valid && room_for_two;
   assign push_count     = accept ? emit_count : 2'd0;

   explex_step u_step (
      .state       (state_ff),
      .char_code   (req_chan.char_code),
      .end_of_text (req_chan.end_of_text),
      .state_in    (state_in),
      .token0      (token0),
      .token1      (token1),
      .emit_count  (emit_count)
   );

   explex_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push0        (token0),
      .push1        (token1),
      .room_for_two (room_for_two),
      .rsp_chan     (rsp_chan)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode      <= explex_pkg::MODE_IDLE;
         state_ff.run_start <= '0;
         state_ff.position  <= '0;
         state_ff.emitted   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/explex_checker.sv =====
// Port-level checks for the expression lexer, bound to the top level.
// Depends on explex_pkg and expression_lexer_macros.svh.
`include "expression_lexer_macros.svh"

module explex_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [explex_pkg::KindBits-1:0]   rsp_token_kind,
   input logic [explex_pkg::FieldBits-1:0]  rsp_token_start,
   input logic [explex_pkg::FieldBits-1:0]  rsp_token_length,
   input logic [explex_pkg::FieldBits-1:0]  rsp_token_serial,
   input logic                              rsp_last_of_run
);

   // A stalled token keeps its contents.
   `EXPLEX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_token_kind) && $stable(rsp_token_start) && $stable(rsp_token_length) && $stable(rsp_token_serial) && $stable(rsp_last_of_run), "stalled token changed")

   // Reset empties the token queue.
   `EXPLEX_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "token valid after reset")

   // The second token of a character is queued together with the first.
   `EXPLEX_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run, rsp_valid && rsp_token_serial == $past(rsp_token_serial) + 16'd1, "second token of a pair missing")

endmodule

bind expression_lexer explex_checker u_explex_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_token_kind   (rsp_chan.token_kind),
   .rsp_token_start  (rsp_chan.token_start),
   .rsp_token_length (rsp_chan.token_length),
   .rsp_token_serial (rsp_chan.token_serial),
   .rsp_last_of_run  (rsp_chan.last_of_run)
);
